>>> design/abmf_pkg.sv
// Shared types and constants of the ARGB box mean filter.
`timescale 1ns / 1ps
package abmf_pkg;

  localparam int unsigned PixW       = 32;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 4;
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 13;
  localparam int unsigned CfgRadiusW = 2;
  localparam int unsigned RowW       = 12;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [CfgWidthW-1:0]  WidthRst  = 11'd640;
  localparam logic [CfgHeightW-1:0] HeightRst = 13'd480;
  localparam logic [CfgRadiusW-1:0] RadiusRst = 2'd1;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } reg_idx_e;

  // Per-request control that follows a result down the pipeline.
  typedef struct packed {
    logic                  last;
    logic [CfgRadiusW-1:0] radius;
  } tag_t;

endpackage

>>> design/abmf_if.sv
// Stream channels of the ARGB box mean filter.
`timescale 1ns / 1ps
interface abmf_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] pixel_argb;

  modport source(output valid, output mode, output pixel_argb, input ready);
  modport sink(input valid, input mode, input pixel_argb, output ready);
endinterface

interface abmf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mean_argb;
  logic        frame_last;

  modport source(output valid, output mean_argb, output frame_last, input ready);
  modport sink(input valid, input mean_argb, input frame_last, output ready);
endinterface

>>> design/abmf_line_buf.sv
// Line store: one memory word per column holds the pixels of the previous rows.
`timescale 1ns / 1ps
module abmf_line_buf #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_RADIUS = 3
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]                  rd_addr_i,
  input  logic [abmf_pkg::PixW-1:0]                     pix_i,
  input  logic                                          adv_i,
  output logic [2*MAX_RADIUS:0][abmf_pkg::PixW-1:0]     col_o
);
  import abmf_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned NT    = 2 * MAX_RADIUS + 1;
  localparam int unsigned Slots = 2 * MAX_RADIUS;

  logic [Slots-1:0][PixW-1:0] mem_q [MAX_WIDTH];
  logic [Slots-1:0][PixW-1:0] rd_q;
  logic [Slots-1:0][PixW-1:0] fwd_word_q;
  logic [Slots-1:0][PixW-1:0] old_w;
  logic [Slots-1:0][PixW-1:0] new_word;
  logic [AW-1:0]              addr1_q;
  logic [PixW-1:0]            pix1_q;
  logic                       fwd_q;

  // A write and a read of the same column at one edge: take the written word.
  assign old_w = fwd_q ? fwd_word_q : rd_q;

  always_comb begin
    col_o[0] = pix1_q;
    for (int j = 1; j < NT; j++) begin
      col_o[j] = old_w[j-1];
    end
    for (int i = 0; i < Slots; i++) begin
      new_word[i] = col_o[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mem_q[addr1_q] <= new_word;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      addr1_q    <= rd_addr_i;
      pix1_q     <= pix_i;
      fwd_word_q <= new_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= adv_i && (addr1_q == rd_addr_i);
    end
  end

endmodule

>>> design/abmf_window.sv
// Window registers, masked channel sums and the divide by the window area.
`timescale 1ns / 1ps
module abmf_window #(
  parameter int unsigned MAX_RADIUS = 3
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      adv_i,
  input  logic                                      emit_i,
  input  abmf_pkg::tag_t                            tag_i,
  input  logic [2*MAX_RADIUS:0]                     row_ok_i,
  input  logic [2*MAX_RADIUS:0]                     col_ok_i,
  input  logic [2*MAX_RADIUS:0][abmf_pkg::PixW-1:0] col_i,
  input  logic                                      out_rdy_i,
  output logic                                      s2_rdy_o,
  output logic                                      res_v_o,
  output logic [abmf_pkg::PixW-1:0]                 res_mean_o,
  output logic                                      res_last_o
);
  import abmf_pkg::*;

  localparam int unsigned NT = 2 * MAX_RADIUS + 1;
  localparam int unsigned CW = $clog2(NT * 255 + 1);
  localparam int unsigned SW = $clog2(NT * NT * 255 + 1);
  localparam int unsigned K  = SW + 8;
  localparam int unsigned RW = K + 1;
  localparam int unsigned PW = SW + RW;

  logic [NT-1:0][NT-1:0][PixW-1:0] win_q;

  logic                            v2_q, v3_q, v4_q, v5_q;
  logic                            rdy3, rdy4, rdy5;
  tag_t                            tag2_q, tag3_q, tag4_q;
  logic                            last5_q;
  logic [NT-1:0]                   rok2_q, cok2_q;
  logic [NT-1:0][NumChan-1:0][CW-1:0] csum_d, csum3_q;
  logic [NumChan-1:0][SW-1:0]      tot_d, tot4_q;
  logic [NumChan-1:0][PW-1:0]      prod5_q;
  logic [RW-1:0]                   recip_w [MAX_RADIUS+1];
  logic [RW-1:0]                   recip_sel;

  assign rdy5     = !v5_q || out_rdy_i;
  assign rdy4     = !v4_q || rdy5;
  assign rdy3     = !v3_q || rdy4;
  assign s2_rdy_o = !v2_q || rdy3;

  // Reciprocal of the window area, exact for every reachable sum.
  for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
    localparam longint unsigned Div = (2 * g + 1) * (2 * g + 1);
    localparam longint unsigned Rc  = ((64'd1 << K) + Div - 1) / Div;
    assign recip_w[g] = RW'(Rc);
  end

  always_comb begin
    recip_sel = recip_w[0];
    for (int g = 0; g <= MAX_RADIUS; g++) begin
      if (32'(tag4_q.radius) == g) begin
        recip_sel = recip_w[g];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NT; k++) begin
      for (int c = 0; c < NumChan; c++) begin
        csum_d[k][c] = '0;
        for (int j = 0; j < NT; j++) begin
          if (rok2_q[j] && cok2_q[k]) begin
            csum_d[k][c] = csum_d[k][c] + CW'(win_q[k][j][c*ChanW +: ChanW]);
          end
        end
      end
    end
    for (int c = 0; c < NumChan; c++) begin
      tot_d[c] = '0;
      for (int k = 0; k < NT; k++) begin
        tot_d[c] = tot_d[c] + SW'(csum3_q[k][c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      win_q  <= {win_q[NT-2:0], col_i};
      tag2_q <= tag_i;
      rok2_q <= row_ok_i;
      cok2_q <= col_ok_i;
    end
    if (rdy3 && v2_q) begin
      csum3_q <= csum_d;
      tag3_q  <= tag2_q;
    end
    if (rdy4 && v3_q) begin
      tot4_q <= tot_d;
      tag4_q <= tag3_q;
    end
    if (rdy5 && v4_q) begin
      for (int c = 0; c < NumChan; c++) begin
        prod5_q[c] <= PW'(tot4_q[c]) * PW'(recip_sel);
      end
      last5_q <= tag4_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv_i) begin
        v2_q <= emit_i;
      end else if (rdy3) begin
        v2_q <= 1'b0;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      res_mean_o[c*ChanW +: ChanW] = prod5_q[c][K +: ChanW];
    end
  end

  assign res_v_o    = v5_q;
  assign res_last_o = last5_q;

endmodule

>>> design/argb_box_mean_filter.sv
// Top level of the ARGB box mean filter: registers, stream counters, output stage.
//
//   channel  direction  carries                          handshake
//   in_if    sink       mode, pixel_argb                 valid / ready
//   out_if   source     mean_argb, frame_last            valid / ready
//   apb      slave      width, height, radius registers  psel / penable, pready tied high
//
// One pixel per clock unless out_if stalls; the line store column word is read at accept
// and written back when stage 1 advances, so the memory port pair sets the rate.
// A result passes stage 1, the window, column sum, total, product and output registers.
// Reset clears counters and valid bits; line store and window hold no reset value.
// A stall on out_if backs up the stages in turn and then drops in_if.ready.
`timescale 1ns / 1ps
module argb_box_mean_filter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_RADIUS = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  abmf_in_if.sink                           in_if,
  abmf_out_if.source                        out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [abmf_pkg::ApbAddrW-1:0]     paddr,
  input  logic [abmf_pkg::ApbDataW-1:0]     pwdata,
  output logic [abmf_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);
  import abmf_pkg::*;

  localparam int unsigned NT  = 2 * MAX_RADIUS + 1;
  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int unsigned XTW = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
  localparam int unsigned YTW = CfgHeightW;

  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [CfgRadiusW-1:0] radius_q;
  logic                  cfg_wr, cfg_hit;

  logic [WW-1:0]         w_eff;
  logic [YTW-1:0]        h_eff;
  logic [CfgRadiusW-1:0] r_eff;
  logic [DW-1:0]         delay;

  logic [AW-1:0]         in_col_q, ox_q;
  logic [RowW-1:0]       in_row_q, oy_q;
  logic                  past_q;
  logic [DW-1:0]         pre_q;

  logic                  in_fire, in_rdy, adv1, rdy2;
  logic                  col_end, row_end, emit, out_last;
  logic [PixW-1:0]       pix_w;
  logic [YTW-1:0]        ty;
  logic [XTW-1:0]        tx;
  logic [NT-1:0]         row_ok, col_ok;

  logic                  s1_v_q, s1_emit_q;
  tag_t                  s1_tag_q;
  logic [NT-1:0]         s1_rok_q, s1_cok_q;
  logic [NT-1:0][PixW-1:0] col_w;

  logic                  res_v, res_last, out_rdy;
  logic [PixW-1:0]       res_mean;
  logic                  out_v_q, out_last_q;
  logic [PixW-1:0]       out_mean_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_hit = 1'b0;
    prdata  = '0;
    case (reg_idx_e'(paddr[3:2]))
      REG_WIDTH: begin
        cfg_hit = 1'b1;
        prdata  = ApbDataW'(width_q);
      end
      REG_HEIGHT: begin
        cfg_hit = 1'b1;
        prdata  = ApbDataW'(height_q);
      end
      REG_RADIUS: begin
        cfg_hit = 1'b1;
        prdata  = ApbDataW'(radius_q);
      end
      default: begin
        cfg_hit = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      radius_q <= RadiusRst;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_WIDTH:  width_q  <= pwdata[CfgWidthW-1:0];
        REG_HEIGHT: height_q <= pwdata[CfgHeightW-1:0];
        REG_RADIUS: radius_q <= pwdata[CfgRadiusW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry
  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = YTW'(1);
    end else if (32'(height_q) > MaxHeight) begin
      h_eff = YTW'(MaxHeight);
    end else begin
      h_eff = height_q;
    end
    if (32'(radius_q) > MAX_RADIUS) begin
      r_eff = CfgRadiusW'(MAX_RADIUS);
    end else begin
      r_eff = radius_q;
    end
    delay = DW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
  end

  // Stream position and output position
  assign in_rdy      = !s1_v_q || rdy2;
  assign in_if.ready = in_rdy;
  assign in_fire     = in_if.valid && in_rdy;
  assign adv1        = s1_v_q && rdy2;

  assign col_end  = (WW'(in_col_q) == w_eff - WW'(1));
  assign row_end  = (YTW'(in_row_q) == h_eff - YTW'(1));
  assign emit     = (pre_q == delay);
  assign out_last = (WW'(ox_q) == w_eff - WW'(1)) && (YTW'(oy_q) == h_eff - YTW'(1));
  assign pix_w    = (in_if.mode || past_q) ? '0 : in_if.pixel_argb;

  // Window taps outside the image read as zero.
  always_comb begin
    ty = YTW'(oy_q) + YTW'(r_eff);
    tx = XTW'(ox_q) + XTW'(r_eff);
    for (int j = 0; j < NT; j++) begin
      row_ok[j] = (j <= 2 * int'(r_eff)) && (ty >= YTW'(j)) && ((ty - YTW'(j)) < h_eff);
      col_ok[j] = (j <= 2 * int'(r_eff)) && (tx >= XTW'(j)) && ((tx - XTW'(j)) < XTW'(w_eff));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      past_q   <= 1'b0;
      pre_q    <= '0;
      ox_q     <= '0;
      oy_q     <= '0;
    end else if (cfg_wr && cfg_hit) begin
      in_col_q <= '0;
      in_row_q <= '0;
      past_q   <= 1'b0;
      pre_q    <= '0;
      ox_q     <= '0;
      oy_q     <= '0;
    end else if (in_fire) begin
      if (emit && out_last) begin
        in_col_q <= '0;
        in_row_q <= '0;
        past_q   <= 1'b0;
        pre_q    <= '0;
        ox_q     <= '0;
        oy_q     <= '0;
      end else begin
        if (col_end) begin
          in_col_q <= '0;
          if (!past_q) begin
            if (row_end) begin
              past_q <= 1'b1;
            end else begin
              in_row_q <= in_row_q + RowW'(1);
            end
          end
        end else begin
          in_col_q <= in_col_q + AW'(1);
        end
        if (!emit) begin
          pre_q <= pre_q + DW'(1);
        end else if (WW'(ox_q) == w_eff - WW'(1)) begin
          ox_q <= '0;
          oy_q <= oy_q + RowW'(1);
        end else begin
          ox_q <= ox_q + AW'(1);
        end
      end
    end
  end

  // Stage 1 control, aligned with the line store read data
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_emit_q <= emit;
      s1_tag_q  <= '{last: out_last, radius: r_eff};
      s1_rok_q  <= row_ok;
      s1_cok_q  <= col_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_fire) begin
      s1_v_q <= 1'b1;
    end else if (adv1) begin
      s1_v_q <= 1'b0;
    end
  end

  abmf_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .rd_addr_i(in_col_q),
    .pix_i    (pix_w),
    .adv_i    (adv1),
    .col_o    (col_w)
  );

  abmf_window #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv1),
    .emit_i    (s1_emit_q),
    .tag_i     (s1_tag_q),
    .row_ok_i  (s1_rok_q),
    .col_ok_i  (s1_cok_q),
    .col_i     (col_w),
    .out_rdy_i (out_rdy),
    .s2_rdy_o  (rdy2),
    .res_v_o   (res_v),
    .res_mean_o(res_mean),
    .res_last_o(res_last)
  );

  // Output register
  assign out_rdy = !out_v_q || out_if.ready;

  always_ff @(posedge clk_i) begin
    if (out_rdy && res_v) begin
      out_mean_q <= res_mean;
      out_last_q <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= res_v;
    end
  end

  assign out_if.valid      = out_v_q;
  assign out_if.mean_argb  = out_mean_q;
  assign out_if.frame_last = out_last_q;

  a_pre_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pre_q <= delay)
    else $error("fill counter past the output delay");

  a_ox_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(ox_q) < w_eff)
    else $error("output column beyond image width");

  a_oy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    YTW'(oy_q) < h_eff)
    else $error("output row beyond image height");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit && out_last) |=>
      (pre_q == '0 && ox_q == '0 && oy_q == '0 && in_col_q == '0 && !past_q))
    else $error("counters not restarted after frame end");

endmodule
